[hw/rtl/canonical_huffman_encoder_core_assert.svh]
// assertion macros used by the encoder core
`ifndef CANONICAL_HUFFMAN_ENCODER_CORE_ASSERT_SVH
`define CANONICAL_HUFFMAN_ENCODER_CORE_ASSERT_SVH
`ifndef SYNTH
`define CHE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("encoder core assertion failed");
`define CHE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("encoder core assertion failed");
`else
`define CHE_ASSERT(lbl, clk, rst, prop)
`define CHE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[hw/rtl/chenc_pkg.sv]
`default_nettype none
package chenc_pkg;

  // default sizes
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 16;

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int SYM_IN_W = 8;
  localparam int LEN_IN_W = 5;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 3;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_ENCODE = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_t;

  // input transaction
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [SYM_IN_W-1:0] symbol;
    logic [LEN_IN_W-1:0] code_length;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } out_item_t;

  // top level sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC_RD,
    ST_BLD_CNT,
    ST_BLD_NC,
    ST_BLD_CODE,
    ST_BLD_TAIL
  } state_t;

  // bit packer states
  typedef enum logic [1:0] {
    PK_IDLE,
    PK_SHIFT,
    PK_FLUSH
  } pk_state_t;

  // requests from sequencer to bit packer
  typedef struct packed {
    logic start;
    logic flush;
  } pk_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/chenc_packer.sv]
`default_nettype none
module chenc_packer #(
  parameter int MAX_CODE_LEN = chenc_pkg::MAX_CODE_LEN_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire  chenc_pkg::pk_ctl_t              ctl,
  input  wire  [MAX_CODE_LEN-1:0]               code,
  input  wire  [$clog2(MAX_CODE_LEN+1)-1:0]     len,
  output logic                                  busy,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output chenc_pkg::out_item_t                  out_data
);

  localparam int NC_W  = MAX_CODE_LEN;
  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

  chenc_pkg::pk_state_t state, state_next;

  logic [NC_W-1:0]                  sr;
  logic [LEN_W-1:0]                 bits_left;
  logic [chenc_pkg::BYTE_W-1:0]     bit_buffer;
  logic [chenc_pkg::POS_W-1:0]      bit_position;

  logic                             can_emit;
  logic                             full;
  logic                             step;
  logic                             emit_flush;
  logic [chenc_pkg::BYTE_W-1:0]     buf_ins;

  assign can_emit = !out_valid || !out_stall;
  assign full     = (bit_position == {chenc_pkg::POS_W{1'b1}});
  assign busy     = (state != chenc_pkg::PK_IDLE);

  // buffer with the current code bit placed at the fill position
  always_comb begin
    buf_ins = bit_buffer;
    buf_ins[bit_position] = sr[NC_W-1];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chenc_pkg::PK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and step control
  always_comb begin
    state_next = state;
    step       = 1'b0;
    emit_flush = 1'b0;
    unique case (state)
      chenc_pkg::PK_IDLE: begin
        if (ctl.start) begin
          state_next = chenc_pkg::PK_SHIFT;
        end else if (ctl.flush && bit_position != '0) begin
          state_next = chenc_pkg::PK_FLUSH;
        end
      end
      chenc_pkg::PK_SHIFT: begin
        // a completed byte waits for room in the output register
        if (!full || can_emit) begin
          step = 1'b1;
          if (bits_left == LEN_W'(1)) begin
            state_next = chenc_pkg::PK_IDLE;
          end
        end
      end
      chenc_pkg::PK_FLUSH: begin
        if (can_emit) begin
          emit_flush = 1'b1;
          state_next = chenc_pkg::PK_IDLE;
        end
      end
      default: state_next = chenc_pkg::PK_IDLE;
    endcase
  end

  // shift register and bit counter
  always_ff @(posedge clk) begin
    if (state == chenc_pkg::PK_IDLE && ctl.start) begin
      sr        <= code;
      bits_left <= len;
    end else if (step) begin
      sr        <= sr << 1;
      bits_left <= bits_left - LEN_W'(1);
    end
  end

  // byte accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer   <= '0;
      bit_position <= '0;
    end else if (emit_flush || (step && full)) begin
      bit_buffer   <= '0;
      bit_position <= '0;
    end else if (step) begin
      bit_buffer   <= buf_ins;
      bit_position <= bit_position + chenc_pkg::POS_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_flush || (step && full)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_flush) begin
      out_data.out_byte    <= bit_buffer;
      out_data.last_of_run <= 1'b1;
    end else if (step && full) begin
      // last when the bits still to come cannot fill another byte
      out_data.out_byte    <= buf_ins;
      out_data.last_of_run <= (int'(bits_left) <= chenc_pkg::BYTE_W);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/canonical_huffman_encoder_core.sv]
// Canonical Huffman byte encoder. Commands: load stores one code length,
// build assigns canonical codes, encode appends a symbol's code (MSB first)
// into bytes filled from bit 0, flush emits a partial byte. One transaction
// is in work at a time. Encode shifts the code into the byte buffer one bit
// per cycle, except while a completed byte waits for room in the output
// register. Build walks the length table twice and the length list once, as
// the length table has a single read port. The length table comes out of
// reset empty through per-entry valid bits; no clearing pass is needed.
`default_nettype none
`include "canonical_huffman_encoder_core_assert.svh"
module canonical_huffman_encoder_core #(
  parameter int SYMBOL_COUNT = chenc_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = chenc_pkg::MAX_CODE_LEN_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  chenc_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire                        out_stall,
  output chenc_pkg::out_item_t       out_data
);

  localparam int SYM_W = $clog2(SYMBOL_COUNT);
  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int NC_W  = MAX_CODE_LEN;
  localparam int CNT_W = $clog2(SYMBOL_COUNT + 1);

  chenc_pkg::state_t state, state_next;
  chenc_pkg::pk_ctl_t pk_ctl;
  logic pk_busy;

  // tables
  logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] len_vld;
  logic [NC_W-1:0]         code_mem [SYMBOL_COUNT];
  logic [CNT_W-1:0]        counts   [1:MAX_CODE_LEN];
  logic [NC_W-1:0]         nc       [1:MAX_CODE_LEN];

  // read pipeline
  logic [SYM_W-1:0] rd_addr;
  logic [LEN_W-1:0] len_rd;
  logic             vld_rd;
  logic [NC_W-1:0]  code_rd;
  logic [LEN_W-1:0] len_eff;
  logic             sym_ok_q;

  // build counters
  logic [SYM_W-1:0] s_cnt;
  logic [SYM_W-1:0] s_d;
  logic [LEN_W-1:0] len_cnt;
  logic             cnt_v;
  logic             code_v;

  logic                     in_acc;
  logic                     bld_acc;
  chenc_pkg::cmd_t          in_cmd;
  logic                     sym_ok;
  logic                     s_last;
  logic                     len_last;
  logic [NC_W-1:0]          prev_nc;
  logic [CNT_W-1:0]         prev_cnt;
  logic [NC_W+CNT_W-1:0]    nc_sum;
  logic [NC_W-1:0]          nc_calc;
  logic [NC_W-1:0]          code_mask;
  logic [NC_W-1:0]          code_wr;
  logic [NC_W-1:0]          code_aligned;
  logic [LEN_W-1:0]         len_store;

  assign in_stall = (state != chenc_pkg::ST_IDLE) || pk_busy;
  assign in_acc   = in_valid && !in_stall;
  assign in_cmd   = chenc_pkg::cmd_t'(in_data.cmd);
  assign bld_acc  = in_acc && (in_cmd == chenc_pkg::CMD_BUILD);
  assign sym_ok   = ({1'b0, in_data.symbol} < (chenc_pkg::SYM_IN_W + 1)'(SYMBOL_COUNT));
  assign s_last   = (s_cnt == SYM_W'(SYMBOL_COUNT - 1));
  assign len_last = (len_cnt == LEN_W'(MAX_CODE_LEN));
  assign len_eff  = vld_rd ? len_rd : '0;
  assign rd_addr  = (state == chenc_pkg::ST_IDLE) ? SYM_W'(in_data.symbol) : s_cnt;

  // lengths above the maximum are stored as absent
  assign len_store = (int'(in_data.code_length) <= MAX_CODE_LEN) ?
                     LEN_W'(in_data.code_length) : '0;

  // first code of one length from the previous length
  assign prev_nc  = (len_cnt == LEN_W'(1)) ? '0 : nc[len_cnt - LEN_W'(1)];
  assign prev_cnt = (len_cnt == LEN_W'(1)) ? '0 : counts[len_cnt - LEN_W'(1)];
  assign nc_sum   = {{CNT_W{1'b0}}, prev_nc} + {{NC_W{1'b0}}, prev_cnt};
  assign nc_calc  = NC_W'(nc_sum << 1);

  // code assigned to the symbol coming out of the read pipeline
  assign code_mask = ~({NC_W{1'b1}} << len_eff);
  assign code_wr   = (len_eff != '0) ? (nc[len_eff] & code_mask) : '0;

  // code moved to the top of the shift register
  assign code_aligned = code_rd << (LEN_W'(MAX_CODE_LEN) - len_eff);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chenc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and packer requests
  always_comb begin
    state_next   = state;
    pk_ctl.start = 1'b0;
    pk_ctl.flush = 1'b0;
    unique case (state)
      chenc_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            chenc_pkg::CMD_LOAD:   state_next = chenc_pkg::ST_IDLE;
            chenc_pkg::CMD_BUILD:  state_next = chenc_pkg::ST_BLD_CNT;
            chenc_pkg::CMD_ENCODE: state_next = chenc_pkg::ST_ENC_RD;
            chenc_pkg::CMD_FLUSH:  pk_ctl.flush = 1'b1;
            default:               state_next = chenc_pkg::ST_IDLE;
          endcase
        end
      end
      chenc_pkg::ST_ENC_RD: begin
        pk_ctl.start = sym_ok_q && (len_eff != '0);
        state_next   = chenc_pkg::ST_IDLE;
      end
      chenc_pkg::ST_BLD_CNT: begin
        if (s_last) begin
          state_next = chenc_pkg::ST_BLD_NC;
        end
      end
      chenc_pkg::ST_BLD_NC: begin
        if (len_last) begin
          state_next = chenc_pkg::ST_BLD_CODE;
        end
      end
      chenc_pkg::ST_BLD_CODE: begin
        if (s_last) begin
          state_next = chenc_pkg::ST_BLD_TAIL;
        end
      end
      chenc_pkg::ST_BLD_TAIL: state_next = chenc_pkg::ST_IDLE;
      default:                state_next = chenc_pkg::ST_IDLE;
    endcase
  end

  // length table memory
  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == chenc_pkg::CMD_LOAD && sym_ok) begin
      len_mem[SYM_W'(in_data.symbol)] <= len_store;
    end
    len_rd <= len_mem[rd_addr];
  end

  // length table valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      len_vld <= '0;
      vld_rd  <= 1'b0;
    end else begin
      if (in_acc && in_cmd == chenc_pkg::CMD_LOAD && sym_ok) begin
        len_vld[SYM_W'(in_data.symbol)] <= 1'b1;
      end
      vld_rd <= len_vld[rd_addr];
    end
  end

  // code table memory
  always_ff @(posedge clk) begin
    if (code_v) begin
      code_mem[s_d] <= code_wr;
    end
    code_rd <= code_mem[rd_addr];
  end

  // symbol range flag for the encode read
  always_ff @(posedge clk) begin
    sym_ok_q <= sym_ok;
  end

  // build walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      s_cnt   <= '0;
      len_cnt <= LEN_W'(1);
      cnt_v   <= 1'b0;
      code_v  <= 1'b0;
    end else begin
      cnt_v  <= (state == chenc_pkg::ST_BLD_CNT);
      code_v <= (state == chenc_pkg::ST_BLD_CODE);
      if (state == chenc_pkg::ST_BLD_CNT || state == chenc_pkg::ST_BLD_CODE) begin
        s_cnt <= s_last ? '0 : s_cnt + SYM_W'(1);
      end else if (state == chenc_pkg::ST_IDLE) begin
        s_cnt <= '0;
      end
      if (state == chenc_pkg::ST_BLD_NC) begin
        len_cnt <= len_last ? LEN_W'(1) : len_cnt + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    s_d <= s_cnt;
  end

  // symbols per length
  always_ff @(posedge clk) begin
    if (rst || bld_acc) begin
      for (int i = 1; i <= MAX_CODE_LEN; i++) begin
        counts[i] <= '0;
      end
    end else if (cnt_v && len_eff != '0) begin
      counts[len_eff] <= counts[len_eff] + CNT_W'(1);
    end
  end

  // next code per length
  always_ff @(posedge clk) begin
    if (state == chenc_pkg::ST_BLD_NC) begin
      nc[len_cnt] <= nc_calc;
    end else if (code_v && len_eff != '0) begin
      nc[len_eff] <= nc[len_eff] + NC_W'(1);
    end
  end

  // bit packer and output register
  chenc_packer #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_packer (
    .clk       (clk),
    .rst       (rst),
    .ctl       (pk_ctl),
    .code      (code_aligned),
    .len       (len_eff),
    .busy      (pk_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // checks
  `CHE_ASSERT(a_pk_idle_in_walk, clk, rst, (state != chenc_pkg::ST_IDLE) |-> !pk_busy)
  `CHE_ASSERT(a_build_starts, clk, rst, bld_acc |=> (state == chenc_pkg::ST_BLD_CNT))
  `CHE_ASSERT(a_out_from_packer, clk, rst, $rose(out_valid) |-> $past(pk_busy))

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_HALF    = 6;
  localparam int RST_CYCLES  = 8;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 600;
  localparam int DRAIN_LIMIT = 20000;
  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEM_TARGET = 420;

  // expected byte stream of the encoder, kept in step with accepted commands
  class huffman_byte_scoreboard;
    bit [4:0]  len_tab  [chenc_pkg::SYMBOL_COUNT_DEF];
    bit [15:0] code_tab [chenc_pkg::SYMBOL_COUNT_DEF];
    bit        codes_built;
    bit [7:0]  pend_bits;
    bit [2:0]  fill_pos;
    chenc_pkg::out_item_t expected_bytes [$];
    int        mismatch_count;
    int        bytes_checked;
    int        accepted;
    int        builds;

    function new();
      foreach (len_tab[s]) begin
        len_tab[s]  = '0;
        code_tab[s] = '0;
      end
      codes_built    = 1'b0;
      pend_bits      = '0;
      fill_pos       = '0;
      mismatch_count = 0;
      bytes_checked  = 0;
      accepted       = 0;
      builds         = 0;
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      $display("MISMATCH: %s", msg);
    endtask

    function int pending();
      return expected_bytes.size();
    endfunction

    // count lengths, derive first code per length, hand out codes by symbol
    function void assign_canonical_codes();
      bit [8:0]  per_len    [chenc_pkg::MAX_CODE_LEN_DEF+1];
      bit [15:0] first_code [chenc_pkg::MAX_CODE_LEN_DEF+1];
      bit [16:0] mask;
      int        s;
      int        l;
      for (l = 0; l <= chenc_pkg::MAX_CODE_LEN_DEF; l++) per_len[l] = '0;
      for (s = 0; s < chenc_pkg::SYMBOL_COUNT_DEF; s++)
        if (len_tab[s] != 0) per_len[len_tab[s]] = per_len[len_tab[s]] + 9'd1;
      first_code[0] = '0;
      for (l = 1; l <= chenc_pkg::MAX_CODE_LEN_DEF; l++)
        first_code[l] = (first_code[l-1] + ((l == 1) ? 16'd0 : 16'(per_len[l-1]))) << 1;
      for (s = 0; s < chenc_pkg::SYMBOL_COUNT_DEF; s++) begin
        l = len_tab[s];
        if (l != 0) begin
          mask        = (17'd1 << l) - 17'd1;
          code_tab[s] = first_code[l] & mask[15:0];
          first_code[l] = first_code[l] + 16'd1;
        end else begin
          code_tab[s] = '0;
        end
      end
    endfunction

    function void note_accepted_command(chenc_pkg::in_item_t it);
      int        l;
      int        i;
      int        emitted;
      bit [15:0] code;
      chenc_pkg::out_item_t ob;
      accepted++;
      case (chenc_pkg::cmd_t'(it.cmd))
        chenc_pkg::CMD_LOAD: begin
          if (it.symbol < chenc_pkg::SYMBOL_COUNT_DEF)
            len_tab[it.symbol] = (it.code_length <= chenc_pkg::MAX_CODE_LEN_DEF) ?
                                 it.code_length : 5'd0;
        end
        chenc_pkg::CMD_BUILD: begin
          assign_canonical_codes();
          codes_built = 1'b1;
          builds++;
        end
        chenc_pkg::CMD_ENCODE: begin
          l       = len_tab[it.symbol];
          code    = code_tab[it.symbol];
          emitted = 0;
          // msb of the code first, byte fills from bit 0
          for (i = l; i > 0; i--) begin
            pend_bits[fill_pos] = code[i-1];
            fill_pos = fill_pos + 3'd1;
            if (fill_pos == 0) begin
              ob.out_byte    = pend_bits;
              ob.last_of_run = 1'b0;
              expected_bytes.insert(expected_bytes.size(), ob);
              pend_bits = '0;
              emitted++;
            end
          end
          if (emitted > 0)
            expected_bytes[expected_bytes.size() - 1].last_of_run = 1'b1;
        end
        default: begin
          // flush of an empty buffer emits nothing
          if (fill_pos != 0) begin
            ob.out_byte    = pend_bits;
            ob.last_of_run = 1'b1;
            expected_bytes.insert(expected_bytes.size(), ob);
            pend_bits = '0;
            fill_pos  = '0;
          end
        end
      endcase
    endfunction

    task check_emitted_byte(chenc_pkg::out_item_t got);
      chenc_pkg::out_item_t want;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last_of_run %0b",
                                  got.out_byte, got.last_of_run));
        return;
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("byte %0d: out_byte %02h, want %02h",
                                  bytes_checked, got.out_byte, want.out_byte));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("byte %0d: last_of_run %0b, want %0b",
                                  bytes_checked, got.last_of_run, want.last_of_run));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  chenc_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  chenc_pkg::out_item_t out_data;

  logic      quiet = 1'b0;
  int        hold_req = 0;
  int        hold_seen = 0;
  int        hold_left = 0;
  int        cycle_count = 0;

  huffman_byte_scoreboard sb;

  canonical_huffman_encoder_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: check each accepted byte, then pick the next stall value
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_emitted_byte(out_data);
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 35);
    end
  end

  // offer one command and hold it until the block takes it
  task automatic send_item(input chenc_pkg::cmd_t c, input int unsigned sym,
                           input int unsigned len);
    chenc_pkg::in_item_t it;
    it.cmd         = c;
    it.symbol      = sym[7:0];
    it.code_length = len[4:0];
    if (!quiet && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_accepted_command(it);
  endtask

  // sender pause until every expected byte is out
  task automatic drain_output();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (sb.pending() != 0 && waited < DRAIN_LIMIT);
  endtask

  // random commands, full field ranges
  task automatic send_noise();
    int unsigned n;
    int unsigned c;
    int unsigned sym;
    n = $urandom_range(6, 12);
    repeat (n) begin
      c   = $urandom_range(3);
      sym = $urandom_range(255);
      // never encode a present symbol before any code assignment
      if (chenc_pkg::cmd_t'(c) == chenc_pkg::CMD_ENCODE && !sb.codes_built &&
          sb.len_tab[sym] != 0) c = chenc_pkg::CMD_FLUSH;
      send_item(chenc_pkg::cmd_t'(c), sym, $urandom_range(31));
    end
  endtask

  // maybe retire old table, load new lengths, build, encode a run, maybe flush
  task automatic run_table_phase();
    int unsigned depth_q [$];
    int unsigned present [$];
    bit          taken [chenc_pkg::SYMBOL_COUNT_DEF];
    int unsigned leaves;
    int unsigned pick;
    int unsigned d;
    int unsigned s;
    int unsigned n_enc;
    int          i;
    bit          kraft_ok;
    for (i = 0; i < chenc_pkg::SYMBOL_COUNT_DEF; i++) taken[i] = 1'b0;
    if ($urandom_range(4) != 0) begin
      for (i = 0; i < chenc_pkg::SYMBOL_COUNT_DEF; i++)
        if (sb.len_tab[i] != 0)
          send_item(chenc_pkg::CMD_LOAD, i, $urandom_range(1) ? 0 : $urandom_range(17, 31));
    end
    // grow a full prefix tree by splitting leaves, deep leaves favored
    kraft_ok = ($urandom_range(4) != 0);
    leaves   = $urandom_range(2, 24);
    depth_q  = '{1, 1};
    while (depth_q.size() < leaves) begin
      pick = $urandom_range(1) ? depth_q.size() - 1 : $urandom_range(depth_q.size() - 1);
      d = depth_q[pick];
      if (d < chenc_pkg::MAX_CODE_LEN_DEF) begin
        depth_q.delete(pick);
        depth_q.insert(depth_q.size(), d + 1);
        depth_q.insert(depth_q.size(), d + 1);
      end
    end
    if (!kraft_ok)
      foreach (depth_q[k]) depth_q[k] = $urandom_range(1, chenc_pkg::MAX_CODE_LEN_DEF);
    foreach (depth_q[k]) begin
      do s = $urandom_range(255); while (taken[s]);
      taken[s] = 1'b1;
      send_item(chenc_pkg::CMD_LOAD, s, depth_q[k]);
    end
    send_item(chenc_pkg::CMD_BUILD, $urandom_range(255), $urandom_range(31));
    for (i = 0; i < chenc_pkg::SYMBOL_COUNT_DEF; i++)
      if (sb.len_tab[i] != 0) present.insert(present.size(), i);
    n_enc = $urandom_range(8, 40);
    repeat (n_enc) begin
      if (present.size() != 0 && $urandom_range(9) != 0)
        s = present[$urandom_range(present.size() - 1)];
      else
        s = $urandom_range(255);
      send_item(chenc_pkg::CMD_ENCODE, s, $urandom_range(31));
    end
    if ($urandom_range(3) != 0)
      send_item(chenc_pkg::CMD_FLUSH, $urandom_range(255), $urandom_range(31));
  endtask

  initial begin
    int phase;
    sb = new();
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty flush, absent symbol, extreme lengths, oversize lengths
    send_item(chenc_pkg::CMD_FLUSH, 8'hff, 5'h1f);
    send_item(chenc_pkg::CMD_ENCODE, 7, 0);
    send_item(chenc_pkg::CMD_LOAD, 0, 1);
    send_item(chenc_pkg::CMD_LOAD, 255, 16);
    send_item(chenc_pkg::CMD_LOAD, 1, 2);
    send_item(chenc_pkg::CMD_LOAD, 2, 3);
    send_item(chenc_pkg::CMD_LOAD, 3, 31);
    send_item(chenc_pkg::CMD_LOAD, 4, 16);
    send_item(chenc_pkg::CMD_LOAD, 9, 17);
    send_item(chenc_pkg::CMD_BUILD, 0, 0);
    send_item(chenc_pkg::CMD_ENCODE, 255, 5'h1f);
    send_item(chenc_pkg::CMD_ENCODE, 0, 0);
    send_item(chenc_pkg::CMD_ENCODE, 1, 0);
    send_item(chenc_pkg::CMD_ENCODE, 2, 0);
    send_item(chenc_pkg::CMD_ENCODE, 4, 0);
    send_item(chenc_pkg::CMD_ENCODE, 3, 0);
    send_item(chenc_pkg::CMD_ENCODE, 9, 0);
    send_item(chenc_pkg::CMD_FLUSH, 0, 0);
    send_item(chenc_pkg::CMD_FLUSH, 0, 0);
    // over-full length set: codes get truncated
    send_item(chenc_pkg::CMD_LOAD, 5, 1);
    send_item(chenc_pkg::CMD_LOAD, 6, 1);
    send_item(chenc_pkg::CMD_BUILD, 8'hff, 5'h1f);
    send_item(chenc_pkg::CMD_ENCODE, 6, 0);
    send_item(chenc_pkg::CMD_ENCODE, 5, 0);
    send_item(chenc_pkg::CMD_ENCODE, 0, 0);
    send_item(chenc_pkg::CMD_FLUSH, 0, 0);
    drain_output();

    // random phases with one long output hold, one quiet stretch, one drain
    phase = 0;
    while (sb.accepted < ITEM_TARGET) begin
      if (phase == 1) hold_req <= hold_req + 1;
      if (phase == 3) quiet <= 1'b1;
      if (phase == 4) quiet <= 1'b0;
      if (phase == 5) drain_output();
      if ($urandom_range(3) == 0) send_noise();
      else run_table_phase();
      phase++;
    end

    // wind down
    drain_output();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected bytes never came out", sb.pending()));

    $display("run covered %0d commands, %0d code builds, %0d bytes checked",
             sb.accepted, sb.builds, sb.bytes_checked);
    $display("with random gaps, a long output hold, a quiet stretch and %0d mismatches",
             sb.mismatch_count);
    if (sb.mismatch_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[canonical_huffman_encoder_core.f]
+incdir+hw/rtl
hw/rtl/chenc_pkg.sv
hw/rtl/chenc_packer.sv
hw/rtl/canonical_huffman_encoder_core.sv
sim/tb_top.sv
